>>> rtl/crc16_pkg.sv
// ----------------------------------------------------------------------------
// crc16_pkg
// Shared constants and types of the bytewise crc16 engine.
// ----------------------------------------------------------------------------
package crc16_pkg;

	localparam int CRC_W      = 16;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CRC_W-1:0] CRC_POLY = 16'hC86C;

	// register indexes of the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FINAL_XOR  = 4'd1;

	typedef struct packed {
		logic [CRC_W-1:0] init_value;
		logic [CRC_W-1:0] final_xor;
	} crc16_cfg_t;

	typedef struct packed {
		logic s1_valid;
		logic s1_last;
		logic res_full;
	} crc16_status_t;

endpackage

>>> rtl/crc16_if.sv
// ----------------------------------------------------------------------------
// crc16 channel interfaces
// Byte input, crc result and configuration write channels.
// ----------------------------------------------------------------------------
interface crc16_byte_if import crc16_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              first_byte;
	logic              last_byte;

	modport source (output valid, data_byte, first_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface crc16_crc_if import crc16_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CRC_W-1:0] crc_value;

	modport source (output valid, crc_value, input ready);
	modport sink   (input valid, crc_value, output ready);
endinterface

interface crc16_cfg_if import crc16_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/crc16_cfg_regs.sv
// ----------------------------------------------------------------------------
// crc16_cfg_regs
// Holds the init value and final xor mask written over the config channel.
// ----------------------------------------------------------------------------
module crc16_cfg_regs import crc16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	crc16_cfg_if.sink   cfg,
	output crc16_cfg_t  regs
);

	logic [CRC_W-1:0] init_value_q;
	logic [CRC_W-1:0] final_xor_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_value_q <= '0;
			final_xor_q  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			// writes to unknown indexes are dropped
			case (cfg.index)
				REG_INIT_VALUE: init_value_q <= cfg.data[CRC_W-1:0];
				REG_FINAL_XOR:  final_xor_q  <= cfg.data[CRC_W-1:0];
				default: ;
			endcase
		end
	end

	assign regs.init_value = init_value_q;
	assign regs.final_xor  = final_xor_q;

endmodule

>>> rtl/crc16_datapath.sv
// ----------------------------------------------------------------------------
// crc16_datapath
// Input register, byte fold into the running remainder, result register.
// ----------------------------------------------------------------------------
module crc16_datapath import crc16_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  crc16_cfg_t    regs,
	crc16_byte_if.sink    data,
	crc16_crc_if.source   result,
	output crc16_status_t status
);

	function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] rem,
	                                               input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] r;
		r = rem ^ {b, {(CRC_W-BYTE_W){1'b0}}};
		for (int k = 0; k < BYTE_W; k++) begin
			if (r[CRC_W-1]) begin
				r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[CRC_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              first_s1;
	logic              last_s1;

	logic [CRC_W-1:0]  remainder_q;
	logic              res_valid_q;
	logic [CRC_W-1:0]  crc_q;

	logic              s1_go;
	logic [CRC_W-1:0]  start_rem;
	logic [CRC_W-1:0]  next_rem;

	// a last byte waits in s1 only while the result register is full and stalled
	assign s1_go      = valid_s1 && (!last_s1 || !res_valid_q || result.ready);
	assign data.ready = !valid_s1 || s1_go;

	assign start_rem = first_s1 ? regs.init_value : remainder_q;
	assign next_rem  = fold_byte(start_rem, byte_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data.ready) begin
			valid_s1 <= data.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data.valid && data.ready) begin
			byte_s1  <= data.data_byte;
			first_s1 <= data.first_byte;
			last_s1  <= data.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remainder_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (s1_go) begin
				remainder_q <= next_rem;
			end
			if (s1_go && last_s1) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			crc_q <= next_rem ^ regs.final_xor;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.crc_value = crc_q;

	assign status.s1_valid = valid_s1;
	assign status.s1_last  = last_s1;
	assign status.res_full = res_valid_q;

endmodule

>>> rtl/crc16_bytewise_engine.sv
// ----------------------------------------------------------------------------
// crc16_bytewise_engine
// MSB-first crc16 over a byte stream, generator 0xC86C.
// ----------------------------------------------------------------------------
// usage:
//   data   : one message byte per transaction, with first_byte and last_byte
//            marks; a first byte restarts the remainder from init_value
//   result : one crc_value per last byte, remainder xor final_xor
//   cfg    : register writes, index 0 init_value, index 1 final_xor;
//            always ready, unknown indexes ignored; write only while idle
// throughput: one byte per cycle, set by the single-cycle 8-step xor fold
//   between the input register and the result register
// latency: a last byte accepted at edge n shows its crc after edge n+1
// reset: registers, remainder and both channels clear; no clearing pass
// stall: a finished crc waits in the result register while non-last bytes
//   keep flowing; a further last byte holds in the input register and
//   data.ready drops until the result is taken
// ----------------------------------------------------------------------------
module crc16_bytewise_engine import crc16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	crc16_cfg_if.sink   cfg,
	crc16_byte_if.sink  data,
	crc16_crc_if.source result
);

	crc16_cfg_t    regs;
	crc16_status_t status;

	crc16_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	crc16_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.data   (data),
		.result (result),
		.status (status)
	);

`ifndef ASSERT_OFF
	// a pending last byte behind a stalled result blocks the input
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		status.s1_valid && status.s1_last && result.valid && !result.ready
		|-> !data.ready)
		else $error("input ready while a last byte is blocked");

	// non-last bytes never stall the input
	a_nonlast_flows: assert property (@(posedge clk) disable iff (!arst_n)
		!status.s1_valid || !status.s1_last |-> data.ready)
		else $error("input stalled without a blocked last byte");

	// an accepted byte lands in the input register
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		data.valid && data.ready |=> status.s1_valid)
		else $error("accepted byte lost");

	// the result register follows its status view
	a_res_status: assert property (@(posedge clk) disable iff (!arst_n)
		status.res_full == result.valid)
		else $error("result valid out of step with status");
`endif

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the bytewise crc16 engine against a bit-serial fold of each byte.
// Directed corner bytes first, then random messages and stray bytes under
// several init and final mask settings. Sender bursts and receiver stalls
// vary throughout the run.
// ----------------------------------------------------------------------------
module tb;
	import crc16_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RAND_ITEMS     = 1290;
	localparam int NUM_PHASES     = 6;
	localparam int MAX_REPORTS    = 10;

	// indexes outside the register map, writes to them must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 4'hF;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              first_byte;
		logic              last_byte;
	} byte_item_t;

	logic clk;
	logic arst_n;

	crc16_cfg_if  cfg_bus ();
	crc16_byte_if byte_bus ();
	crc16_crc_if  crc_bus ();

	crc16_bytewise_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.data   (byte_bus),
		.result (crc_bus)
	);

	byte_item_t       byte_q[$];
	logic [CRC_W-1:0] crc_expect_q[$];
	byte_item_t       next_item;
	logic [CRC_W-1:0] crc_seed;
	logic [CRC_W-1:0] crc_mask;
	logic [CRC_W-1:0] crc_rem;
	logic [CRC_W-1:0] crc_start;
	logic [CRC_W-1:0] crc_want;
	logic [15:0]      ready_pattern;
	int               bytes_pending = 0;
	int               fail_count    = 0;
	int               quiet_cycles  = 0;
	int               burst_left;
	int               gap_left;
	int               pattern_age;

	function automatic logic [CRC_W-1:0] crc16_fold(logic [CRC_W-1:0] rem,
			logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] r;
		r = rem ^ {b, 8'h00};
		for (int k = 0; k < BYTE_W; k++) begin
			r = r[CRC_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	task automatic push_byte(logic [BYTE_W-1:0] b, logic f, logic l);
		byte_item_t item;
		item.data_byte  = b;
		item.first_byte = f;
		item.last_byte  = l;
		bytes_pending++;
		byte_q.push_back(item);
	endtask

	// mostly framed messages, some loose bytes with random marks
	task automatic push_random(int n);
		int left;
		int len;
		left = n;
		while (left > 0) begin
			if ($urandom_range(0, 9) < 8) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					push_byte(BYTE_W'($urandom_range(0, 255)), i == 0, i == len - 1);
				left -= len;
			end else begin
				push_byte(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				left--;
			end
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		if (idx == REG_INIT_VALUE)
			crc_seed = value;
		else if (idx == REG_FINAL_XOR)
			crc_mask = value;
	endtask

	// a non-last byte may still sit in the input register, hence the tail
	task automatic wait_idle();
		do @(posedge clk); while (bytes_pending != 0 || crc_expect_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// byte driver, predicts on every accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_bus.valid      <= 1'b0;
			byte_bus.data_byte  <= '0;
			byte_bus.first_byte <= 1'b0;
			byte_bus.last_byte  <= 1'b0;
			crc_seed   = '0;
			crc_mask   = '0;
			crc_rem    = '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (byte_bus.valid && byte_bus.ready) begin
				crc_start = byte_bus.first_byte ? crc_seed : crc_rem;
				crc_rem   = crc16_fold(crc_start, byte_bus.data_byte);
				if (byte_bus.last_byte)
					crc_expect_q.push_back(crc_rem ^ crc_mask);
				bytes_pending--;
			end
			if (!byte_bus.valid || byte_bus.ready) begin
				if (gap_left > 0 || byte_q.size() == 0) begin
					byte_bus.valid <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end else begin
					next_item = byte_q.pop_front();
					byte_bus.valid      <= 1'b1;
					byte_bus.data_byte  <= next_item.data_byte;
					byte_bus.first_byte <= next_item.first_byte;
					byte_bus.last_byte  <= next_item.last_byte;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// result monitor with its own stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_bus.ready <= 1'b0;
			ready_pattern = 16'hFFFF;
			pattern_age   = 0;
		end else begin
			if (crc_bus.valid && crc_bus.ready) begin
				if (crc_expect_q.size() == 0) begin
					note_failure($sformatf("crc result with nothing pending: got %h",
						crc_bus.crc_value));
				end else begin
					crc_want = crc_expect_q.pop_front();
					if (crc_bus.crc_value !== crc_want)
						note_failure($sformatf("crc_value mismatch: expected %h got %h",
							crc_want, crc_bus.crc_value));
				end
			end
			crc_bus.ready <= ready_pattern[0];
			ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
			pattern_age++;
			if (pattern_age == 64) begin
				pattern_age = 0;
				case ($urandom_range(0, 3))
					0: ready_pattern = 16'hFFFF;
					1: ready_pattern = 16'h0001;
					default: ready_pattern = 16'($urandom()) | 16'h0001;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_bus.valid && byte_bus.ready) || (crc_bus.valid && crc_bus.ready) ||
					(cfg_bus.valid && cfg_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] next_init;
		logic [CFG_DATA_W-1:0] next_mask;

		arst_n              = 1'b0;
		cfg_bus.valid       = 1'b0;
		cfg_bus.index       = '0;
		cfg_bus.data        = '0;
		byte_bus.valid      = 1'b0;
		byte_bus.data_byte  = '0;
		byte_bus.first_byte = 1'b0;
		byte_bus.last_byte  = 1'b0;
		crc_bus.ready       = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: bytes before any first mark fold into the cleared remainder
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b1);
		push_byte(8'hA5, 1'b1, 1'b1);
		// continues from the remainder left by the last message
		push_byte(8'h3C, 1'b0, 1'b0);
		push_byte(8'h01, 1'b0, 1'b1);
		push_byte(8'hFF, 1'b1, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'h55, 1'b0, 1'b0);
		push_byte(8'hAA, 1'b0, 1'b1);
		push_byte(8'hFF, 1'b1, 1'b1);
		push_byte(8'h00, 1'b1, 1'b1);
		// restart in the middle of a message
		push_byte(8'h12, 1'b1, 1'b0);
		push_byte(8'h34, 1'b1, 1'b0);
		push_byte(8'h56, 1'b0, 1'b1);
		push_byte(8'h80, 1'b1, 1'b1);
		push_byte(8'h7F, 1'b0, 1'b1);
		// left open across the first register writes
		push_byte(8'hC3, 1'b1, 1'b0);
		wait_idle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin next_init = 16'hFFFF; next_mask = 16'hFFFF; end
				1: begin next_init = 16'hFFFF; next_mask = 16'h0000; end
				2: begin next_init = 16'h0000; next_mask = 16'hFFFF; end
				default: begin
					next_init = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
					next_mask = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
				end
			endcase
			write_reg(REG_INIT_VALUE, next_init);
			write_reg(REG_FINAL_XOR, next_mask);
			if (p == 0)
				write_reg(REG_UNMAPPED_HI, 16'h5A5A);
			if (p == 3)
				write_reg(REG_UNMAPPED_LO, 16'hA5A5);
			if (p == 0)
				push_byte(8'h99, 1'b0, 1'b1);
			push_random(RAND_ITEMS / NUM_PHASES);
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

>>> files.f
rtl/crc16_pkg.sv
rtl/crc16_if.sv
rtl/crc16_cfg_regs.sv
rtl/crc16_datapath.sv
rtl/crc16_bytewise_engine.sv
dv/tb.sv
